>>> design/assert_macros.svh
// Assertion macros shared by the link set-up modules.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LSH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define LSH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define LSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lsh_pkg.sv
// Shared types, codes and frame constants for the SET/UA link set-up block.
// No dependencies; used by lsh_ctrl, lsh_tx and the top level.
`default_nettype none

package lsh_pkg;

  // Fixed field widths.
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned ATTEMPT_W  = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FRAME_LEN  = 5;
  localparam int unsigned FRAME_IDX_W = 3;

  // Reset values of the configuration registers.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3;
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_RESET = 4'd4;

  // Frame bytes.
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ADDR_SND  = 8'h01;
  localparam logic [BYTE_W-1:0] CTL_SET   = 8'h03;
  localparam logic [BYTE_W-1:0] CTL_UA    = 8'h07;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // Operation codes carried on the input tuser.
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Link status codes as reported on the output.
  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd3;

  // Link phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_CONN = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  // UA frame recogniser, one-hot.
  typedef enum logic [4:0] {
    M_HUNT  = 5'b00001,
    M_FLAG  = 5'b00010,
    M_ADDR  = 5'b00100,
    M_CTRL  = 5'b01000,
    M_CHECK = 5'b10000
  } match_t;

  // Output job handed from the controller to the transmitter.
  typedef struct packed {
    logic                send_set;
    logic [STATUS_W-1:0] status;
  } job_t;

  // Status code of a phase.
  function automatic logic [STATUS_W-1:0] phase_code(input phase_t ph);
    logic [STATUS_W-1:0] code;
    case (ph)
      PH_IDLE: code = ST_IDLE;
      PH_WAIT: code = ST_WAIT;
      PH_CONN: code = ST_CONN;
      PH_FAIL: code = ST_FAIL;
      default: code = ST_IDLE;
    endcase
    return code;
  endfunction

  // Byte k of the SET frame: flag, address, control, check, flag.
  function automatic logic [BYTE_W-1:0] set_byte(input logic [FRAME_IDX_W-1:0] k);
    logic [BYTE_W-1:0] b;
    case (k)
      3'd0:    b = FLAG_BYTE;
      3'd1:    b = ADDR_SND;
      3'd2:    b = CTL_SET;
      3'd3:    b = ADDR_SND ^ CTL_SET;
      3'd4:    b = FLAG_BYTE;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/lsh_ctrl.sv
// Link controller: phase, UA recogniser, tick and expiry counters.
// Depends on lsh_pkg and assert_macros.svh.
`default_nettype none

module lsh_ctrl #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [lsh_pkg::OP_W-1:0]         op,
  input  wire logic [lsh_pkg::BYTE_W-1:0]       rx_byte,
  input  wire logic [lsh_pkg::TIMEOUT_W-1:0]    timeout_ticks,
  input  wire logic [lsh_pkg::ATTEMPT_W-1:0]    max_attempts,
  output lsh_pkg::job_t                         job
);

  localparam int unsigned CW    = TICK_COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW + 1 > lsh_pkg::TIMEOUT_W) ? CW + 1 : lsh_pkg::TIMEOUT_W;

  lsh_pkg::phase_t              phase_r,  phase_nxt;
  lsh_pkg::match_t              match_r,  match_nxt;
  logic [CW-1:0]                tick_r,   tick_nxt;
  logic [lsh_pkg::ATTEMPT_W-1:0] expiry_r, expiry_nxt;

  logic [CW:0]                  tick_inc;
  logic                         expire;
  logic [lsh_pkg::ATTEMPT_W-1:0] expiry_inc;
  logic                         give_up;
  lsh_pkg::match_t              match_step;
  logic                         ua_done;

  // Timeout comparison; an overflow of the counter at its own width also counts as expiry.
  assign tick_inc   = {1'b0, tick_r} + {{CW{1'b0}}, 1'b1};
  assign expire     = (CMP_W'(tick_inc) >= CMP_W'(timeout_ticks)) || tick_inc[CW];
  assign expiry_inc = expiry_r + lsh_pkg::ATTEMPT_W'(1);
  assign give_up    = (expiry_inc >= max_attempts) || (expiry_inc == '0);

  // UA recogniser step for the received byte.
  always_comb begin
    match_step = lsh_pkg::M_HUNT;
    ua_done    = 1'b0;
    case (match_r)
      lsh_pkg::M_HUNT: begin
        match_step = (rx_byte == lsh_pkg::FLAG_BYTE) ? lsh_pkg::M_FLAG : lsh_pkg::M_HUNT;
      end
      lsh_pkg::M_FLAG: begin
        if (rx_byte == lsh_pkg::ADDR_SND) match_step = lsh_pkg::M_ADDR;
        else if (rx_byte == lsh_pkg::FLAG_BYTE) match_step = lsh_pkg::M_FLAG;
      end
      lsh_pkg::M_ADDR: begin
        if (rx_byte == lsh_pkg::CTL_UA) match_step = lsh_pkg::M_CTRL;
        else if (rx_byte == lsh_pkg::FLAG_BYTE) match_step = lsh_pkg::M_FLAG;
      end
      lsh_pkg::M_CTRL: begin
        if (rx_byte == (lsh_pkg::ADDR_SND ^ lsh_pkg::CTL_UA)) match_step = lsh_pkg::M_CHECK;
        else if (rx_byte == lsh_pkg::FLAG_BYTE) match_step = lsh_pkg::M_FLAG;
      end
      lsh_pkg::M_CHECK: begin
        ua_done = (rx_byte == lsh_pkg::FLAG_BYTE);
      end
      default: begin
        match_step = lsh_pkg::M_HUNT;
      end
    endcase
  end

  // Next state and the output job for the item being handled.
  always_comb begin
    phase_nxt    = phase_r;
    match_nxt    = match_r;
    tick_nxt     = tick_r;
    expiry_nxt   = expiry_r;
    job.send_set = 1'b0;
    if (op == lsh_pkg::OP_START) begin
      phase_nxt    = lsh_pkg::PH_WAIT;
      match_nxt    = lsh_pkg::M_HUNT;
      tick_nxt     = '0;
      expiry_nxt   = '0;
      job.send_set = 1'b1;
    end else if (phase_r == lsh_pkg::PH_WAIT) begin
      if (op == lsh_pkg::OP_BYTE) begin
        // A zero byte leaves the recogniser untouched.
        if (rx_byte != lsh_pkg::ZERO_BYTE) begin
          match_nxt = match_step;
          if (ua_done) phase_nxt = lsh_pkg::PH_CONN;
        end
      end else if (op == lsh_pkg::OP_TICK) begin
        if (expire) begin
          tick_nxt   = '0;
          expiry_nxt = expiry_inc;
          if (give_up) begin
            phase_nxt = lsh_pkg::PH_FAIL;
            match_nxt = lsh_pkg::M_HUNT;
          end else begin
            job.send_set = 1'b1;
          end
        end else begin
          tick_nxt = tick_inc[CW-1:0];
        end
      end
    end
    job.status = lsh_pkg::phase_code(phase_nxt);
  end

  // State registers, updated once per handled item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lsh_pkg::PH_IDLE;
      match_r  <= lsh_pkg::M_HUNT;
      tick_r   <= '0;
      expiry_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      match_r  <= match_nxt;
      tick_r   <= tick_nxt;
      expiry_r <= expiry_nxt;
    end
  end

`include "assert_macros.svh"

  // Outside the waiting phase the recogniser always rests in hunt.
  `LSH_ASSERT_IMPL(a_hunt_outside_wait, phase_r != lsh_pkg::PH_WAIT, match_r == lsh_pkg::M_HUNT, "recogniser active outside the waiting phase")
  // A start always leaves the block waiting with a cleared tick counter.
  `LSH_ASSERT_NEXT(a_start_clears, step && op == lsh_pkg::OP_START, phase_r == lsh_pkg::PH_WAIT && tick_r == '0 && expiry_r == '0, "start did not reset the handshake")

endmodule

`default_nettype wire

>>> design/lsh_tx.sv
// Result transmitter: holds one job and plays out its beats.
// Depends on lsh_pkg and assert_macros.svh.
`default_nettype none

module lsh_tx (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire lsh_pkg::job_t                     job,
  output logic                                   free,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_tx_valid,
  output logic [lsh_pkg::BYTE_W-1:0]             out_byte,
  output logic [lsh_pkg::STATUS_W-1:0]           out_status,
  output logic                                   out_last
);

  logic                                 vld_r,  vld_nxt;
  lsh_pkg::job_t                        job_r;
  logic [lsh_pkg::FRAME_IDX_W-1:0]      idx_r,  idx_nxt;
  logic                                 fire;

  // Beat contents follow from the held job and the beat index.
  assign out_valid    = vld_r;
  assign out_tx_valid = job_r.send_set;
  assign out_byte     = job_r.send_set ? lsh_pkg::set_byte(idx_r) : lsh_pkg::ZERO_BYTE;
  assign out_status   = job_r.status;
  assign out_last     = !job_r.send_set ||
                        (idx_r == lsh_pkg::FRAME_IDX_W'(lsh_pkg::FRAME_LEN - 1));

  assign fire = vld_r && out_ready;
  assign free = !vld_r || (fire && out_last);

  // Beat sequencing.
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (fire) begin
      if (out_last) vld_nxt = 1'b0;
      else          idx_nxt = idx_r + lsh_pkg::FRAME_IDX_W'(1);
    end
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Job payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) job_r <= job;
  end

`include "assert_macros.svh"

  // A status-only job never leaves its first beat.
  `LSH_ASSERT_IMPL(a_status_single, vld_r && !job_r.send_set, idx_r == '0, "status beat index moved")
  // A taken frame beat that is not the last advances the index by one.
  `LSH_ASSERT_NEXT(a_idx_step, fire && !out_last, idx_r == $past(idx_r) + lsh_pkg::FRAME_IDX_W'(1), "frame beat skipped or repeated")
  // The load only happens when the job slot is free.
  `LSH_ASSERT_IMPL(a_load_free, load, free, "job overwritten before its last beat")

endmodule

`default_nettype wire

>>> design/link_setup_set_ua_handshake.sv
// Sender side of a SET/UA link set-up. Each accepted input beat is one item: a start sends the
// SET frame (five output beats), a received byte feeds the UA recogniser and a tick advances
// the timeout, which retransmits SET or declares failure; every other item yields one status
// beat. An item is registered on input and handled as it moves into the output job register
// once the job slot frees; its result beats are then played out from that register. The input
// register accepts a new beat while the job register still plays out, so the block takes one
// item per cycle for status-only traffic while out_tready stays high; an item that sends SET
// holds the job slot until its five beats are taken; the output channel's beat count sets the
// sustained rate. Registers: timeout_ticks at byte address 0, max_attempts at byte address 4.
`default_nettype none

module link_setup_set_ua_handshake #(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,    // [1:0] op
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [7:0] tx_byte, [9:8] link_status, [15:10] zero
  output logic [0:0]       out_tuser,   // [0] tx_valid
  output logic             out_tlast,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic                               in_vld_r, in_vld_nxt;
  logic [lsh_pkg::OP_W-1:0]           op_r;
  logic [lsh_pkg::BYTE_W-1:0]         byte_r;
  logic [lsh_pkg::TIMEOUT_W-1:0]      timeout_r;
  logic [lsh_pkg::ATTEMPT_W-1:0]      attempts_r;
  logic                               step;
  logic                               tx_free;
  logic                               cfg_wr;
  lsh_pkg::job_t                      job;
  logic [lsh_pkg::BYTE_W-1:0]         tx_byte;
  logic [lsh_pkg::STATUS_W-1:0]       tx_status;

  // Configuration registers; the low address bits are byte offsets.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= lsh_pkg::TIMEOUT_RESET;
      attempts_r <= lsh_pkg::ATTEMPT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) attempts_r <= cfg_pwdata[lsh_pkg::ATTEMPT_W-1:0];
      else              timeout_r  <= cfg_pwdata[lsh_pkg::TIMEOUT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'(attempts_r) : 32'(timeout_r);

  // Input register: the held item moves on whenever the job slot frees.
  assign step       = in_vld_r && tx_free;
  assign in_tready  = !in_vld_r || step;
  assign in_vld_nxt = (in_tvalid && in_tready) || (in_vld_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  lsh_ctrl #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .op            (op_r),
    .rx_byte       (byte_r),
    .timeout_ticks (timeout_r),
    .max_attempts  (attempts_r),
    .job           (job)
  );

  lsh_tx u_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (step),
    .job          (job),
    .free         (tx_free),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_tx_valid (out_tuser[0]),
    .out_byte     (tx_byte),
    .out_status   (tx_status),
    .out_last     (out_tlast)
  );

  assign out_tdata = {6'd0, tx_status, tx_byte};

`include "assert_macros.svh"

  // A held item is never dropped while waiting for the job slot.
  `LSH_ASSERT_NEXT(a_item_held, in_vld_r && !step, in_vld_r, "held input item lost")

endmodule

`default_nettype wire
